>>> src/ldg_vertex_partition_assign_top_macros.svh
// Assertion helpers for the top-level RTL; clk and arst_n are taken from the enclosing module.
`ifndef LDG_VERTEX_PARTITION_ASSIGN_TOP_MACROS_SVH
`define LDG_VERTEX_PARTITION_ASSIGN_TOP_MACROS_SVH

// same-cycle implication
`define LDG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LDG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ldg_pkg.sv
`default_nettype none

package ldg_pkg;

	localparam int VTX_W        = 16;
	localparam int MAX_VERTICES = 1 << VTX_W;
	localparam int PART_W       = 4;
	localparam int MAX_PARTS    = 1 << PART_W;
	localparam int P_W          = PART_W + 1;
	localparam int SEED_W       = PART_W + 1;
	localparam int CNT_W        = 17;
	localparam int TOT_W        = 17;
	// T - P*size: P*size stays below 2^21, so 22 bits signed
	localparam int CAP_W        = 22;
	localparam int SCORE_W      = CAP_W + CNT_W + 1;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = TOT_W;

	localparam logic [CFG_IDX_W-1:0] REG_PARTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'b1;

	localparam logic [P_W-1:0]   PARTS_RESET = 5'd16;
	localparam logic [TOT_W-1:0] TOTAL_RESET = 17'd65536;

	typedef struct packed {
		logic [VTX_W-1:0] vertex_id;
		logic [VTX_W-1:0] neighbor_id;
		logic             last_neighbor;
	} ldg_in_t;

	typedef struct packed {
		logic [VTX_W-1:0]  vertex_id_out;
		logic [PART_W-1:0] partition;
	} ldg_out_t;

	typedef struct packed {
		logic              valid;
		logic [PART_W-1:0] part;
	} ldg_map_entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic              inc_en;
		logic [PART_W-1:0] inc_idx;
		logic              place_en;
		logic [PART_W-1:0] place_idx;
		logic [P_W-1:0]    p_eff;
		logic [TOT_W-1:0]  total;
	} ldg_ctl_t;

	// running maximum handed along the chain
	typedef struct packed {
		logic                      valid;
		logic                      has_best;
		logic signed [SCORE_W-1:0] best_score;
		logic [PART_W-1:0]         best_idx;
	} ldg_tok_t;

endpackage

`default_nettype wire

>>> src/ldg_vertex_partition_assign_top.sv
// channel | direction | payload                                  | handshake
// in      | input     | vertex_id, neighbor_id, last_neighbor    | in_valid / in_ready
// out     | output    | vertex_id_out, partition                 | out_valid / out_ready
// cfg     | input     | cfg_index, cfg_data                      | cfg_valid / cfg_ready
//
// A neighbour item goes through a map read, then a count update in the owning cell.
// A marked item during seeding goes through count, score and placement steps; after
// seeding a token walks the 16-cell chain one cell per cycle between score and placement.
// After reset the partition map is swept to invalid with in_ready low;
// cfg writes are taken throughout. A held result only stalls the next placement.
`default_nettype none

module ldg_vertex_partition_assign_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire ldg_pkg::ldg_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output ldg_pkg::ldg_out_t                   out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ldg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ldg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ldg_pkg::*;

	`include "ldg_vertex_partition_assign_top_macros.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COUNT = 3'd1;
	localparam logic [2:0] ST_SCORE = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_PLACE = 3'd4;

	logic [2:0]         state_q;
	logic [P_W-1:0]     parts_q;
	logic [TOT_W-1:0]   total_q;
	logic [P_W-1:0]     p_eff;
	logic [SEED_W-1:0]  seeded_q;
	logic [PART_W-1:0]  chosen_q;
	logic [VTX_W-1:0]   vtx_q;
	logic               last_q;
	logic               start_q;
	logic               out_valid_q;
	ldg_out_t           out_q;
	logic               in_fire;
	logic               place_fire;
	logic               map_busy;
	ldg_map_entry_t     map_rd;
	ldg_map_entry_t     map_wr;
	ldg_ctl_t           ctl;
	ldg_tok_t           chain [0:MAX_PARTS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parts_q <= PARTS_RESET;
			total_q <= TOTAL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PARTS: parts_q <= cfg_data[P_W-1:0];
				REG_TOTAL: total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (parts_q == '0)
			p_eff = P_W'(1);
		else if (parts_q > P_W'(MAX_PARTS))
			p_eff = P_W'(MAX_PARTS);
		else
			p_eff = parts_q;
	end

	assign in_ready   = (state_q == ST_IDLE) && !map_busy;
	assign in_fire    = in_valid && in_ready;
	assign place_fire = (state_q == ST_PLACE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			seeded_q <= '0;
			start_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire)
						state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					state_q <= last_q ? ST_SCORE : ST_IDLE;
				end
				ST_SCORE: begin
					if ({1'b0, seeded_q} < {1'b0, p_eff}) begin
						seeded_q <= seeded_q + 1'b1;
						state_q  <= ST_PLACE;
					end else begin
						start_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain[MAX_PARTS].valid)
						state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					if (place_fire)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			vtx_q  <= in_data.vertex_id;
			last_q <= in_data.last_neighbor;
		end
		if (state_q == ST_SCORE)
			chosen_q <= seeded_q[PART_W-1:0];
		else if (state_q == ST_SCAN && chain[MAX_PARTS].valid)
			chosen_q <= chain[MAX_PARTS].best_idx;
	end

	assign map_wr.valid = 1'b1;
	assign map_wr.part  = chosen_q;

	ldg_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (in_data.neighbor_id),
		.rd_data (map_rd),
		.wr_en   (place_fire),
		.wr_addr (vtx_q),
		.wr_data (map_wr),
		.busy    (map_busy)
	);

	always_comb begin
		ctl.inc_en    = (state_q == ST_COUNT) && map_rd.valid;
		ctl.inc_idx   = map_rd.part;
		ctl.place_en  = place_fire;
		ctl.place_idx = chosen_q;
		ctl.p_eff     = p_eff;
		ctl.total     = total_q;
	end

	always_comb begin
		chain[0].valid      = start_q;
		chain[0].has_best   = 1'b0;
		chain[0].best_score = '0;
		chain[0].best_idx   = '0;
	end

	for (genvar g = 0; g < MAX_PARTS; g++) begin : g_cell
		ldg_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (PART_W'(g)),
			.ctl     (ctl),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (place_fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (place_fire) begin
			out_q.vertex_id_out <= vtx_q;
			out_q.partition     <= chosen_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LDG_ASSERT_IMP(a_token_only_in_scan, chain[MAX_PARTS].valid, state_q == ST_SCAN,
		"scan token left the chain outside a scan")
	`LDG_ASSERT_IMP(a_chosen_in_use, state_q == ST_PLACE, {1'b0, chosen_q} < p_eff,
		"chosen partition is not in use")
	`LDG_ASSERT_NXT(a_place_emits, place_fire, out_valid,
		"placement did not raise a result")
	`LDG_ASSERT_NXT(a_accept_counts, in_fire, state_q == ST_COUNT,
		"accepted transaction did not reach the count step")

endmodule

`default_nettype wire

>>> src/ldg_map.sv
`default_nettype none

module ldg_map (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [ldg_pkg::VTX_W-1:0] rd_addr,
	output ldg_pkg::ldg_map_entry_t       rd_data,
	input  wire logic                     wr_en,
	input  wire logic [ldg_pkg::VTX_W-1:0] wr_addr,
	input  wire ldg_pkg::ldg_map_entry_t  wr_data,
	output logic                          busy
);
	import ldg_pkg::*;

	ldg_map_entry_t   mem [MAX_VERTICES];
	ldg_map_entry_t   rd_data_q;
	logic             clearing_q;
	logic [VTX_W-1:0] clr_addr_q;

	// sweep every entry to invalid after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1)
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_addr_q] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign busy    = clearing_q;

endmodule

`default_nettype wire

>>> src/ldg_cell.sv
`default_nettype none

module ldg_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [ldg_pkg::PART_W-1:0] idx,
	input  wire ldg_pkg::ldg_ctl_t         ctl,
	input  wire ldg_pkg::ldg_tok_t         tok_in,
	output ldg_pkg::ldg_tok_t              tok_out
);
	import ldg_pkg::*;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          size_q;
	logic [CAP_W-1:0]          prod;
	logic signed [CAP_W-1:0]   cap_d;
	logic signed [CAP_W-1:0]   cap_q;
	logic signed [SCORE_W-1:0] score_q;
	logic                      active;
	logic                      take;
	logic                      tok_valid_q;
	ldg_tok_t                  tok_d;
	ldg_tok_t                  tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.place_en) begin
			count_q <= '0;
		end else if (ctl.inc_en && ctl.inc_idx == idx && count_q != '1) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (ctl.place_en && ctl.place_idx == idx && size_q != '1) begin
			size_q <= size_q + 1'b1;
		end
	end

	// score pipeline: remaining capacity, then count * capacity
	assign prod  = CAP_W'(ctl.p_eff) * CAP_W'(size_q);
	assign cap_d = $signed({{(CAP_W-TOT_W){1'b0}}, ctl.total}) - $signed(prod);

	always_ff @(posedge clk) begin
		cap_q   <= cap_d;
		score_q <= SCORE_W'($signed({1'b0, count_q}) * cap_q);
	end

	assign active = ({1'b0, idx} < ctl.p_eff);
	assign take   = active && (!tok_in.has_best || score_q > tok_in.best_score);

	always_comb begin
		tok_d            = tok_in;
		tok_d.has_best   = tok_in.has_best | active;
		if (take) begin
			tok_d.best_score = score_q;
			tok_d.best_idx   = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_valid_q <= 1'b0;
		else
			tok_valid_q <= tok_d.valid;
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

`default_nettype wire

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ldg_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int PHASES          = 7;
	localparam int RUN_ITEMS       = 60;
	localparam int PRESSURE_PHASE  = 5;
	localparam int HOLD_OFF_CYCLES = 300;
	// settle time, with margin beyond the longest placement
	localparam int SETTLE_CYCLES   = 40;

	// Tracks the partition map, per-partition neighbour counts and sizes,
	// and queues the placement each marked transaction should produce.
	class partition_tracker;
		ldg_map_entry_t    part_map [MAX_VERTICES];
		logic [CNT_W-1:0]  nb_count [MAX_PARTS];
		logic [CNT_W-1:0]  part_size [MAX_PARTS];
		logic [SEED_W-1:0] seeded;
		logic [P_W-1:0]    parts_reg;
		logic [TOT_W-1:0]  total_reg;
		ldg_out_t          pending_placements [$];
		int                faults;
		int                placements_seen;

		function new();
			int i;
			for (i = 0; i < MAX_VERTICES; i++) begin
				part_map[i] = '0;
			end
			for (i = 0; i < MAX_PARTS; i++) begin
				nb_count[i]  = '0;
				part_size[i] = '0;
			end
			seeded          = '0;
			parts_reg       = PARTS_RESET;
			total_reg       = TOTAL_RESET;
			faults          = 0;
			placements_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_PARTS) begin
				parts_reg = val[P_W-1:0];
			end else if (idx == REG_TOTAL) begin
				total_reg = val[TOT_W-1:0];
			end
		endfunction

		// first partition with the highest count * (T - P*size)
		function logic [PART_W-1:0] best_partition(int p);
			longint score;
			longint top;
			logic [PART_W-1:0] win;
			int i;
			win = '0;
			top = 0;
			for (i = 0; i < p; i++) begin
				score = longint'(nb_count[i]) *
					(longint'(total_reg) - longint'(p) * longint'(part_size[i]));
				if (i == 0 || score > top) begin
					top = score;
					win = i[PART_W-1:0];
				end
			end
			return win;
		endfunction

		function void take_item(ldg_in_t it);
			ldg_map_entry_t    e;
			ldg_out_t          res;
			logic [PART_W-1:0] pick;
			int                p;
			int                i;
			e = part_map[it.neighbor_id];
			if (e.valid && nb_count[e.part] != '1) begin
				nb_count[e.part] = nb_count[e.part] + 1'b1;
			end
			if (!it.last_neighbor) begin
				return;
			end
			if (parts_reg == '0) begin
				p = 1;
			end else if (parts_reg > MAX_PARTS) begin
				p = MAX_PARTS;
			end else begin
				p = parts_reg;
			end
			if (seeded < p) begin
				pick   = seeded[PART_W-1:0];
				seeded = seeded + 1'b1;
			end else begin
				pick = best_partition(p);
			end
			part_map[it.vertex_id] = '{valid: 1'b1, part: pick};
			if (part_size[pick] != '1) begin
				part_size[pick] = part_size[pick] + 1'b1;
			end
			for (i = 0; i < MAX_PARTS; i++) begin
				nb_count[i] = '0;
			end
			res.vertex_id_out = it.vertex_id;
			res.partition     = pick;
			pending_placements.push_back(res);
		endfunction

		function void check_placement(ldg_out_t got);
			ldg_out_t want;
			placements_seen++;
			if (pending_placements.size() == 0) begin
				faults++;
				if (faults <= 10) begin
					$display("unexpected placement: vertex %h partition %0d",
						got.vertex_id_out, got.partition);
				end
				return;
			end
			want = pending_placements.pop_front();
			if (got.vertex_id_out !== want.vertex_id_out
					|| got.partition !== want.partition) begin
				faults++;
				if (faults <= 10) begin
					$display("placement mismatch: expected vertex %h part %0d, got vertex %h part %0d",
						want.vertex_id_out, want.partition, got.vertex_id_out, got.partition);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	ldg_in_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	ldg_out_t              out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	partition_tracker board;
	logic [VTX_W-1:0]  placed_ids [$];
	int                sent_items;
	int                hold_requests;
	bit                steady;

	logic [P_W-1:0]   phase_parts [PHASES] = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd5, 5'd16, 5'd9};
	logic [TOT_W-1:0] phase_total [PHASES] =
		'{17'd12, 17'd65536, 17'd100, 17'd0, 17'd1, 17'd131071, 17'd700};

	ldg_vertex_partition_assign_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [VTX_W-1:0] pick_neighbor();
		if (placed_ids.size() > 0 && $urandom_range(99) < 75) begin
			return placed_ids[$urandom_range(placed_ids.size() - 1)];
		end
		return VTX_W'($urandom);
	endfunction

	// called just after a falling edge, returns just after one
	task automatic offer(input logic [VTX_W-1:0] vid, input logic [VTX_W-1:0] nid,
			input logic last);
		ldg_in_t it;
		int      gap;
		it.vertex_id     = vid;
		it.neighbor_id   = nid;
		it.last_neighbor = last;
		gap = (!steady && $urandom_range(99) < 35) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.take_item(it);
		if (last && placed_ids.size() < 512) begin
			placed_ids.push_back(vid);
		end
		sent_items++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// neighbour transactions give no result, so allow for one still in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending_placements.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_run();
		logic [VTX_W-1:0] vid;
		int               len;
		int               kind;
		int               i;
		kind = $urandom_range(99);
		len  = $urandom_range(1, 6);
		if (placed_ids.size() > 0 && $urandom_range(9) == 0) begin
			vid = placed_ids[$urandom_range(placed_ids.size() - 1)];
		end else begin
			vid = VTX_W'($urandom);
		end
		if (kind < 85) begin
			for (i = 1; i < len; i++) offer(vid, pick_neighbor(), 1'b0);
			offer(vid, pick_neighbor(), 1'b1);
		end else if (kind < 93) begin
			// vertex id wanders mid-run; only the marked one is placed
			for (i = 1; i < len; i++) offer(VTX_W'($urandom), pick_neighbor(), 1'b0);
			offer(vid, pick_neighbor(), 1'b1);
		end else begin
			// unterminated fragment, counts carry into the next run
			for (i = 0; i < len; i++) offer(vid, VTX_W'($urandom), 1'b0);
		end
	endtask

	task automatic directed_runs();
		offer(16'h0000, 16'h0000, 1'b1);
		offer(16'hFFFF, 16'hFFFF, 1'b1);
		// unknown neighbour, and the id changes before the mark
		offer(16'hAAAA, 16'h5555, 1'b0);
		offer(16'h5555, 16'h0000, 1'b1);
		// one neighbour in each seeded partition: three-way tie
		offer(16'h1234, 16'h0000, 1'b0);
		offer(16'h1234, 16'hFFFF, 1'b0);
		offer(16'h1234, 16'h5555, 1'b1);
		offer(16'h1235, 16'hFFFF, 1'b0);
		offer(16'h1235, 16'h5555, 1'b1);
		// same vertex placed a second time
		offer(16'h0000, 16'h5555, 1'b1);
		// nothing known, every score zero
		offer(16'h0F0F, 16'h7777, 1'b1);
		offer(16'hFFFF, 16'h1234, 1'b0);
		offer(16'hFFFF, 16'h1235, 1'b0);
		offer(16'hFFFF, 16'h0000, 1'b0);
		offer(16'hFFFF, 16'hFFFF, 1'b1);
	endtask

	initial begin : stimulus
		int  ph;
		int  start;
		bit  pressed;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		sent_items    = 0;
		hold_requests = 0;
		steady        = 1'b0;
		pressed       = 1'b0;
		board = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			write_reg(REG_PARTS, CFG_DATA_W'(phase_parts[ph]));
			write_reg(REG_TOTAL, CFG_DATA_W'(phase_total[ph]));
			steady = (ph == 2);
			if (ph == 0) begin
				directed_runs();
			end
			start = sent_items;
			while (sent_items - start < RUN_ITEMS) begin
				if (ph == PRESSURE_PHASE && !pressed && sent_items - start >= 20) begin
					hold_requests++;
					pressed = 1'b1;
				end
				random_run();
			end
		end
		wait_idle();
		$display("%0d input transactions, %0d placements checked over %0d P/T settings",
			sent_items, board.placements_seen, PHASES);
		if (board.faults == 0 && board.pending_placements.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	initial begin : result_sink
		int stall_left;
		int holds_done;
		out_ready  = 1'b0;
		stall_left = 0;
		holds_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				stall_left = HOLD_OFF_CYCLES;
			end else if (stall_left == 0 && !steady && $urandom_range(99) < 20) begin
				stall_left = idle_len();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_placement(out_data);
			end
		end
	end

	// covers the map sweep after reset plus the slowest legal run several times over
	initial begin : watchdog
		#6_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
